[design/imu_velocity_integrator_defines.svh]
// ----------------------------------------------------------------------------
// imu_velocity_integrator_defines.svh
// Assertion macros used by imu_velocity_integrator.
// ----------------------------------------------------------------------------
`ifndef IMU_VELOCITY_INTEGRATOR_DEFINES_SVH
`define IMU_VELOCITY_INTEGRATOR_DEFINES_SVH

// same-cycle implication, clocked on clk, off while rst_n is low
`define IVI_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define IVI_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/ivi_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ivi_pkg
// Types and constants of the IMU velocity integrator.
// ----------------------------------------------------------------------------
package ivi_pkg;

    localparam int unsigned FULL_TURN = 5760;

    localparam logic signed [15:0] RST_OFFSET        = 16'sd0;
    localparam logic [12:0]        RST_START_HEADING = 13'd0;
    localparam logic [14:0]        RST_DEAD_ZONE     = 15'd15;
    localparam logic [15:0]        RST_FRICTION_GAIN = 16'd64225;
    localparam logic [30:0]        RST_STOP_SPEED    = 31'd5000;
    localparam logic [15:0]        RST_SHOCK_LIMIT   = 16'd800;

    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 32;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_OFFSET_X      = 3'd0,
        REG_OFFSET_Y      = 3'd1,
        REG_OFFSET_Z      = 3'd2,
        REG_START_HEADING = 3'd3,
        REG_DEAD_ZONE     = 3'd4,
        REG_FRICTION_GAIN = 3'd5,
        REG_STOP_SPEED    = 3'd6,
        REG_SHOCK_LIMIT   = 3'd7
    } ivi_reg_idx_t;

    typedef struct packed {
        logic signed [15:0] raw_accel_x;
        logic signed [15:0] raw_accel_y;
        logic signed [15:0] raw_accel_z;
        logic [15:0]        elapsed_ms;
        logic [12:0]        heading_in;
    } ivi_in_t;

    typedef struct packed {
        logic signed [15:0] accel_x;
        logic signed [15:0] accel_y;
        logic signed [15:0] accel_z;
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
        logic signed [31:0] vel_z;
        logic [15:0]        accel_magnitude;
        logic [31:0]        speed_magnitude;
        logic               shock;
        logic [12:0]        relative_heading;
    } ivi_out_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_ACC,
        ST_SQA_GO,
        ST_SQA_WAIT,
        ST_SQV_GO,
        ST_SQV_WAIT,
        ST_DONE
    } ivi_state_t;

    // what the shared multiplier is doing for the current axis
    typedef enum logic [1:0] {
        K_UPD,
        K_ASQ,
        K_VSQ,
        K_LIM
    } ivi_kind_t;

    typedef struct packed {
        logic        start;
        logic [63:0] radicand;
    } ivi_sq_ctrl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } ivi_sq_stat_t;

    function automatic logic [15:0] abs16(input logic signed [15:0] v);
        abs16 = v[15] ? 16'(-v) : 16'(v);
    endfunction

    function automatic logic [31:0] abs32(input logic signed [31:0] v);
        abs32 = v[31] ? 32'(-v) : 32'(v);
    endfunction

endpackage

[design/imu_velocity_integrator.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imu_velocity_integrator
// Tares IMU acceleration, integrates per-axis speed with deadzone and
// friction decay, and reports magnitudes, shock flag and relative heading.
// ----------------------------------------------------------------------------
//  channel | dir | handshake             | beat
//  --------+-----+-----------------------+--------------------------------
//  in      | in  | in_valid / in_ready   | ivi_in_t sample
//  out     | out | out_valid / out_ready | ivi_out_t result
//  cfg     | in  | cfg_valid / cfg_ready | cfg_index + cfg_data, 1 register
//
//  Each sample runs 10 operations on the shared multiplier (a MUL and an ACC
//  state each), then two 32-step square roots on the one bit-serial root unit.
//  in_ready is high only while idle; a result waiting in the output register
//  does not block a new sample, only the next result write. cfg_ready is
//  always high. Reset clears speeds and loads register defaults.
// ----------------------------------------------------------------------------
`include "imu_velocity_integrator_defines.svh"

module imu_velocity_integrator
    import ivi_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  ivi_in_t               in_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output ivi_out_t              out_data,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam logic signed [14:0] TURN_S = 15'(FULL_TURN);

    // configuration
    logic signed [15:0] offset_reg [3];
    logic [12:0]        start_heading_reg;
    logic [14:0]        dead_zone_reg;
    logic [15:0]        friction_gain_reg;
    logic [30:0]        stop_speed_reg;
    logic [15:0]        shock_limit_reg;

    // sequencer
    ivi_state_t state_reg, state_next;
    ivi_kind_t  kind_reg;
    logic [1:0] axis_reg;
    logic       out_valid_reg;

    // datapath
    logic signed [31:0] speed_reg [3];
    logic signed [15:0] accel_reg [3];
    logic [15:0]        dt_reg;
    logic [12:0]        hd_reg;
    logic [63:0]        asum_reg;
    logic [63:0]        ssum_reg;
    logic               shock_reg;
    logic [15:0]        amag_reg;
    ivi_out_t           out_reg;

    logic               in_accept;
    logic               last_op;
    logic               out_free;
    logic               sq_capture;
    logic               out_load;
    logic [15:0]        abs_a;
    logic [31:0]        abs_v;
    logic               integ;
    logic [31:0]        op_a;
    logic [31:0]        op_b;
    logic [63:0]        product;
    logic signed [31:0] upd_val;
    logic signed [33:0] int_sum;
    logic signed [33:0] inc;
    logic [31:0]        decayed;
    logic signed [14:0] hd_diff;
    logic signed [14:0] rel_hd;
    ivi_sq_ctrl_t       sq_ctrl;
    ivi_sq_stat_t       sq_stat;
    logic [31:0]        sq_root;
    logic signed [15:0] tare [3];

    ivi_mac u_mac (
        .clk     (clk),
        .op_a    (op_a),
        .op_b    (op_b),
        .product (product)
    );

    ivi_isqrt u_isqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (sq_ctrl),
        .stat  (sq_stat),
        .root  (sq_root)
    );

    assign in_accept = in_valid && in_ready;
    assign cfg_ready = 1'b1;
    assign last_op   = (kind_reg == K_LIM);
    assign out_free  = !out_valid_reg || out_ready;

    // ---------------- next state ----------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:     if (in_valid) state_next = ST_MUL;
            ST_MUL:      state_next = ST_ACC;
            ST_ACC:      state_next = last_op ? ST_SQA_GO : ST_MUL;
            ST_SQA_GO:   state_next = ST_SQA_WAIT;
            ST_SQA_WAIT: if (sq_stat.done) state_next = ST_SQV_GO;
            ST_SQV_GO:   state_next = ST_SQV_WAIT;
            ST_SQV_WAIT: if (sq_stat.done) state_next = ST_DONE;
            ST_DONE:     if (out_free) state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    // ---------------- sequencer outputs ----------------
    always_comb
    begin
        in_ready         = 1'b0;
        sq_ctrl.start    = 1'b0;
        sq_ctrl.radicand = asum_reg;
        sq_capture       = 1'b0;
        out_load         = 1'b0;
        case (state_reg)
            ST_IDLE:     in_ready = 1'b1;
            ST_SQA_GO:   sq_ctrl.start = 1'b1;
            ST_SQA_WAIT: sq_capture = sq_stat.done;
            ST_SQV_GO:
            begin
                sq_ctrl.start    = 1'b1;
                sq_ctrl.radicand = ssum_reg;
            end
            ST_SQV_WAIT: sq_ctrl.radicand = ssum_reg;
            ST_DONE:     out_load = out_free;
            default:     in_ready = 1'b0;
        endcase
    end

    // ---------------- operand select ----------------
    assign abs_a = abs16(accel_reg[axis_reg]);
    assign abs_v = abs32(speed_reg[axis_reg]);
    // equal to the deadzone counts as idle
    assign integ = (abs_a > {1'b0, dead_zone_reg});

    always_comb
    begin
        case (kind_reg)
            K_UPD:
            begin
                op_a = integ ? {16'd0, abs_a} : abs_v;
                op_b = integ ? {16'd0, dt_reg} : {16'd0, friction_gain_reg};
            end
            K_ASQ:
            begin
                op_a = {16'd0, abs_a};
                op_b = {16'd0, abs_a};
            end
            K_VSQ:
            begin
                op_a = abs_v;
                op_b = abs_v;
            end
            default:
            begin
                op_a = {16'd0, shock_limit_reg};
                op_b = {16'd0, shock_limit_reg};
            end
        endcase
    end

    // ---------------- axis update ----------------
    always_comb
    begin
        inc     = {2'b00, product[31:0]};
        int_sum = 34'(speed_reg[axis_reg]) + (accel_reg[axis_reg][15] ? -inc : inc);
        decayed = product[47:16];
        if (integ)
        begin
            if (int_sum[33] && !(int_sum[32] && int_sum[31]))
                upd_val = 32'sh8000_0000;
            else if (!int_sum[33] && (int_sum[32] || int_sum[31]))
                upd_val = 32'sh7FFF_FFFF;
            else
                upd_val = int_sum[31:0];
        end
        else if (decayed < {1'b0, stop_speed_reg})
        begin
            upd_val = '0;
        end
        else
        begin
            upd_val = speed_reg[axis_reg][31] ? 32'(-decayed) : 32'(decayed);
        end
    end

    // tare with 16-bit saturation
    always_comb
    begin
        logic signed [16:0] d [3];
        d[0] = 17'(in_data.raw_accel_x) - 17'(offset_reg[0]);
        d[1] = 17'(in_data.raw_accel_y) - 17'(offset_reg[1]);
        d[2] = 17'(in_data.raw_accel_z) - 17'(offset_reg[2]);
        for (int i = 0; i < 3; i++)
        begin
            if (d[i][16] != d[i][15])
                tare[i] = d[i][16] ? 16'sh8000 : 16'sh7FFF;
            else
                tare[i] = d[i][15:0];
        end
    end

    // heading difference lies in -8191..8191
    assign hd_diff = 15'(hd_reg) - 15'(start_heading_reg);

    always_comb
    begin
        if (hd_diff < -TURN_S)
            rel_hd = hd_diff + 15'(2 * FULL_TURN);
        else if (hd_diff < 15'sd0)
            rel_hd = hd_diff + TURN_S;
        else if (hd_diff >= TURN_S)
            rel_hd = hd_diff - TURN_S;
        else
            rel_hd = hd_diff;
    end

    // ---------------- control registers ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            kind_reg      <= K_UPD;
            axis_reg      <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < 3; i++)
            begin
                speed_reg[i]  <= '0;
                offset_reg[i] <= RST_OFFSET;
            end
            start_heading_reg <= RST_START_HEADING;
            dead_zone_reg     <= RST_DEAD_ZONE;
            friction_gain_reg <= RST_FRICTION_GAIN;
            stop_speed_reg    <= RST_STOP_SPEED;
            shock_limit_reg   <= RST_SHOCK_LIMIT;
        end
        else
        begin
            state_reg <= state_next;

            if (out_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;

            if (in_accept)
            begin
                kind_reg <= K_UPD;
                axis_reg <= '0;
            end
            else if (state_reg == ST_ACC)
            begin
                if (kind_reg == K_UPD)
                    speed_reg[axis_reg] <= upd_val;
                if (axis_reg == 2'd2)
                begin
                    axis_reg <= '0;
                    case (kind_reg)
                        K_UPD:   kind_reg <= K_ASQ;
                        K_ASQ:   kind_reg <= K_VSQ;
                        K_VSQ:   kind_reg <= K_LIM;
                        default: kind_reg <= K_LIM;
                    endcase
                end
                else if (!last_op)
                begin
                    axis_reg <= axis_reg + 2'd1;
                end
            end

            if (cfg_valid && cfg_ready)
            begin
                case (ivi_reg_idx_t'(cfg_index))
                    REG_OFFSET_X:      offset_reg[0]     <= cfg_data[15:0];
                    REG_OFFSET_Y:      offset_reg[1]     <= cfg_data[15:0];
                    REG_OFFSET_Z:      offset_reg[2]     <= cfg_data[15:0];
                    REG_START_HEADING: start_heading_reg <= cfg_data[12:0];
                    REG_DEAD_ZONE:     dead_zone_reg     <= cfg_data[14:0];
                    REG_FRICTION_GAIN: friction_gain_reg <= cfg_data[15:0];
                    REG_STOP_SPEED:    stop_speed_reg    <= cfg_data[30:0];
                    REG_SHOCK_LIMIT:   shock_limit_reg   <= cfg_data[15:0];
                    default:           shock_limit_reg   <= shock_limit_reg;
                endcase
            end
        end
    end

    // ---------------- payload registers ----------------
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            for (int i = 0; i < 3; i++)
                accel_reg[i] <= tare[i];
            dt_reg   <= in_data.elapsed_ms;
            hd_reg   <= in_data.heading_in;
            asum_reg <= '0;
            ssum_reg <= '0;
        end
        else if (state_reg == ST_ACC)
        begin
            case (kind_reg)
                K_ASQ:   asum_reg  <= asum_reg + product;
                K_VSQ:   ssum_reg  <= ssum_reg + product;
                K_LIM:   shock_reg <= (asum_reg > product);
                default: asum_reg  <= asum_reg;
            endcase
        end

        if (sq_capture)
            amag_reg <= sq_root[15:0];

        if (out_load)
        begin
            out_reg.accel_x          <= accel_reg[0];
            out_reg.accel_y          <= accel_reg[1];
            out_reg.accel_z          <= accel_reg[2];
            out_reg.vel_x            <= speed_reg[0];
            out_reg.vel_y            <= speed_reg[1];
            out_reg.vel_z            <= speed_reg[2];
            out_reg.accel_magnitude  <= amag_reg;
            out_reg.speed_magnitude  <= sq_root;
            out_reg.shock            <= shock_reg;
            out_reg.relative_heading <= rel_hd[12:0];
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // ---------------- assertions ----------------
    `IVI_ASSERT_IMP(a_idle_root_quiet, in_ready, !sq_stat.busy, "root unit busy while idle")
    `IVI_ASSERT_NXT(a_accept_starts, in_accept, state_reg == ST_MUL, "accepted beat not started")
    `IVI_ASSERT_IMP(a_shock_mag, out_valid && out_data.shock, out_data.accel_magnitude >= shock_limit_reg, "shock below limit")
    `IVI_ASSERT_IMP(a_calm_mag, out_valid && !out_data.shock, out_data.accel_magnitude <= shock_limit_reg, "no shock above limit")

endmodule

[design/ivi_mac.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ivi_mac
// Shared 32x32 unsigned multiplier with a registered product.
// ----------------------------------------------------------------------------
module ivi_mac
    import ivi_pkg::*;
(
    input  logic        clk,
    input  logic [31:0] op_a,
    input  logic [31:0] op_b,
    output logic [63:0] product
);

    logic [63:0] product_reg;

    always_ff @(posedge clk)
    begin
        product_reg <= op_a * op_b;
    end

    assign product = product_reg;

endmodule

[design/ivi_isqrt.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ivi_isqrt
// Bit-serial floor square root of a 64-bit value, one root bit per cycle.
// ----------------------------------------------------------------------------
module ivi_isqrt
    import ivi_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  ivi_sq_ctrl_t ctrl,
    output ivi_sq_stat_t stat,
    output logic [31:0]  root
);

    logic [63:0] n_reg;
    logic [32:0] rem_reg;
    logic [31:0] root_reg;
    logic [4:0]  cnt_reg;
    logic        busy_reg;
    logic        done_reg;

    logic [34:0] rem_sh;
    logic [34:0] trial;
    logic [34:0] diff;
    logic        ge;

    // bring down the next two radicand bits and try root*4+1
    assign rem_sh = {rem_reg, n_reg[63:62]};
    assign trial  = {1'b0, root_reg, 2'b01};
    assign ge     = (rem_sh >= trial);
    assign diff   = rem_sh - trial;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == 5'd31);
            if (ctrl.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 5'd1;
                if (cnt_reg == 5'd31)
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.start)
        begin
            n_reg    <= ctrl.radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            n_reg    <= {n_reg[61:0], 2'b00};
            rem_reg  <= ge ? diff[32:0] : rem_sh[32:0];
            root_reg <= {root_reg[30:0], ge};
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign root      = root_reg;

endmodule

[tb/imu_velocity_integrator_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imu_velocity_integrator_tb
// Self-checking bench for the IMU velocity integrator. A scoreboard keeps
// its own copy of the tare/deadzone/friction integration and predicts each
// result beat. A directed set hits the saturation, deadzone, heading and
// shock edges; random bursts of motion, rest and noise samples then run
// under several register settings with random idle and stall bursts and
// one long output hold-off.
// ----------------------------------------------------------------------------
module imu_velocity_integrator_tb;
    import ivi_pkg::*;

    localparam int LIMIT_CYCLES = 1000000;
    localparam int HOLD_CYCLES  = 400;
    localparam int TAIL_CYCLES  = 120;
    localparam int MAX_PRINT    = 50;
    localparam int RAND_PHASES  = 6;
    localparam int PHASE_ITEMS  = 175;

    typedef enum {MODE_MOVE, MODE_REST, MODE_NOISE} sample_mode_t;

    class ivi_scoreboard;
        localparam longint SPEED_MAX = 64'sd2147483647;
        localparam longint SPEED_MIN = -64'sd2147483648;

        logic signed [15:0] off [3];
        logic [12:0]        start_hdg;
        logic [14:0]        dead_zone;
        logic [15:0]        friction;
        logic [30:0]        stop_spd;
        logic [15:0]        shock_lim;
        logic signed [31:0] speed [3];
        ivi_out_t           pending_results [$];
        int n_err, n_checked, n_shock, n_snap, n_sat;

        function new();
            foreach (off[k]) off[k] = RST_OFFSET;
            foreach (speed[k]) speed[k] = '0;
            start_hdg = RST_START_HEADING;
            dead_zone = RST_DEAD_ZONE;
            friction  = RST_FRICTION_GAIN;
            stop_spd  = RST_STOP_SPEED;
            shock_lim = RST_SHOCK_LIMIT;
            n_err     = 0;
            n_checked = 0;
            n_shock   = 0;
            n_snap    = 0;
            n_sat     = 0;
        endfunction

        function void write_reg(ivi_reg_idx_t idx, logic [31:0] d);
            case (idx)
                REG_OFFSET_X:      off[0]    = d[15:0];
                REG_OFFSET_Y:      off[1]    = d[15:0];
                REG_OFFSET_Z:      off[2]    = d[15:0];
                REG_START_HEADING: start_hdg = d[12:0];
                REG_DEAD_ZONE:     dead_zone = d[14:0];
                REG_FRICTION_GAIN: friction  = d[15:0];
                REG_STOP_SPEED:    stop_spd  = d[30:0];
                REG_SHOCK_LIMIT:   shock_lim = d[15:0];
                default: ;
            endcase
        endfunction

        function bit [63:0] mag(longint v);
            return 64'((v < 0) ? -v : v);
        endfunction

        function logic signed [15:0] tare(logic signed [15:0] raw, logic signed [15:0] o);
            longint d;
            d = longint'(raw) - longint'(o);
            if (d > 32767)
                d = 32767;
            else if (d < -32768)
                d = -32768;
            return 16'(d);
        endfunction

        function logic signed [31:0] step_axis(logic signed [31:0] v, logic signed [15:0] a,
                                               logic [15:0] dt);
            longint     sum;
            bit [63:0]  m;
            if (mag(a) > dead_zone)
            begin
                sum = longint'(v) + longint'(a) * longint'(dt);
                if (sum > SPEED_MAX)
                begin
                    sum = SPEED_MAX;
                    n_sat++;
                end
                else if (sum < SPEED_MIN)
                begin
                    sum = SPEED_MIN;
                    n_sat++;
                end
                return 32'(sum);
            end
            // idle axis: friction decay on the magnitude, sign kept
            m = (mag(v) * friction) >> 16;
            if (m < stop_spd)
            begin
                if (v != 0)
                    n_snap++;
                return '0;
            end
            return (v < 0) ? 32'(-longint'(m)) : 32'(m);
        endfunction

        function bit [63:0] floor_sqrt(bit [63:0] n);
            bit [63:0] r;
            bit [63:0] t;
            r = '0;
            for (int i = 31; i >= 0; i--)
            begin
                t = r | (64'd1 << i);
                if (t * t <= n)
                    r = t;
            end
            return r;
        endfunction

        function void note_sample(ivi_in_t s);
            ivi_out_t           want;
            logic signed [15:0] a [3];
            bit [63:0]          asum;
            bit [63:0]          ssum;
            int                 turn;
            int                 rel;
            a[0] = tare(s.raw_accel_x, off[0]);
            a[1] = tare(s.raw_accel_y, off[1]);
            a[2] = tare(s.raw_accel_z, off[2]);
            asum = '0;
            ssum = '0;
            for (int k = 0; k < 3; k++)
            begin
                speed[k] = step_axis(speed[k], a[k], s.elapsed_ms);
                asum += mag(a[k]) * mag(a[k]);
                ssum += mag(speed[k]) * mag(speed[k]);
            end
            turn = FULL_TURN;
            rel  = (int'(s.heading_in) - int'(start_hdg)) % turn;
            if (rel < 0)
                rel += turn;
            want.accel_x          = a[0];
            want.accel_y          = a[1];
            want.accel_z          = a[2];
            want.vel_x            = speed[0];
            want.vel_y            = speed[1];
            want.vel_z            = speed[2];
            want.accel_magnitude  = 16'(floor_sqrt(asum));
            want.speed_magnitude  = 32'(floor_sqrt(ssum));
            want.shock            = asum > 64'(shock_lim) * 64'(shock_lim);
            want.relative_heading = 13'(rel);
            if (want.shock)
                n_shock++;
            pending_results.push_back(want);
        endfunction

        task report(string msg);
            n_err++;
            // keep the log short when the block is badly off
            if (n_err <= MAX_PRINT)
                $display("MISMATCH t=%0t %s", $time, msg);
        endtask

        task cmp(string fld, logic signed [63:0] got, logic signed [63:0] want);
            if (got !== want)
                report($sformatf("result %0d %s: got %0d want %0d", n_checked, fld, got, want));
        endtask

        task check_result(ivi_out_t got);
            ivi_out_t want;
            if (pending_results.size() == 0)
            begin
                report("result beat with no sample outstanding");
                return;
            end
            want = pending_results.pop_front();
            n_checked++;
            cmp("accel_x", got.accel_x, want.accel_x);
            cmp("accel_y", got.accel_y, want.accel_y);
            cmp("accel_z", got.accel_z, want.accel_z);
            cmp("vel_x", got.vel_x, want.vel_x);
            cmp("vel_y", got.vel_y, want.vel_y);
            cmp("vel_z", got.vel_z, want.vel_z);
            cmp("accel_magnitude", got.accel_magnitude, want.accel_magnitude);
            cmp("speed_magnitude", got.speed_magnitude, want.speed_magnitude);
            cmp("shock", got.shock, want.shock);
            cmp("relative_heading", got.relative_heading, want.relative_heading);
        endtask
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_ready;
    ivi_in_t               in_data;
    logic                  out_valid;
    logic                  out_ready;
    ivi_out_t              out_data;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    ivi_scoreboard sb = new();
    logic [31:0]   cfg_val [8];
    int            gap_pct   = 20;
    int            stall_pct = 20;
    bit            hold_req  = 1'b0;
    int            cycle_cnt = 0;
    int            n_sent    = 0;
    int            n_settings = 0;

    imu_velocity_integrator i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin : watchdog
        while (cycle_cnt < LIMIT_CYCLES)
        begin
            @(posedge clk);
            cycle_cnt++;
        end
        $display("timeout after %0d cycles", cycle_cnt);
        $display("imu_velocity_integrator_tb NOT OK");
        $finish;
    end

    // result side: checks each beat, stalls in bursts, and serves the long hold-off
    initial
    begin : sink
        int stall_left;
        stall_left = 0;
        out_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && out_ready)
                sb.check_result(out_data);
            if (hold_req)
            begin
                hold_req   = 1'b0;
                stall_left = HOLD_CYCLES;
            end
            else if (stall_left == 0 && $urandom_range(1, 100) <= stall_pct)
                stall_left = $urandom_range(1, 6);
            if (stall_left > 0)
            begin
                stall_left--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    task automatic idle_gap();
        if (gap_pct > 0 && $urandom_range(1, 100) <= gap_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    endtask

    task automatic send_sample(ivi_in_t s);
        idle_gap();
        in_data  <= s;
        in_valid <= 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        sb.note_sample(s);
        n_sent++;
    endtask

    task automatic send(int ax, int ay, int az, int dt, int hd);
        ivi_in_t s;
        s.raw_accel_x = 16'(ax);
        s.raw_accel_y = 16'(ay);
        s.raw_accel_z = 16'(az);
        s.elapsed_ms  = 16'(dt);
        s.heading_in  = 13'(hd);
        send_sample(s);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic apply_setting();
        ivi_reg_idx_t r;
        r = REG_OFFSET_X;
        repeat (r.num())
        begin
            cfg_valid <= 1'b1;
            cfg_index <= r;
            cfg_data  <= cfg_val[r];
            do
                @(posedge clk);
            while (!cfg_ready);
            sb.write_reg(r, cfg_val[r]);
            r = r.next();
        end
        cfg_valid <= 1'b0;
        n_settings++;
    endtask

    // field value in the low bits, random junk above it
    function automatic logic [31:0] junk(logic [31:0] v, int w);
        logic [31:0] mask;
        mask = (32'h1 << w) - 32'h1;
        return ($urandom() & ~mask) | (v & mask);
    endfunction

    function automatic logic [31:0] pick(logic [31:0] lo, logic [31:0] hi, logic [31:0] mid);
        case ($urandom_range(0, 7))
            0:       return lo;
            1:       return hi;
            default: return mid;
        endcase
    endfunction

    function automatic void rand_setting();
        cfg_val[REG_OFFSET_X] = junk(pick(32'h8000, 32'h7FFF, $urandom_range(0, 400) - 200), 16);
        cfg_val[REG_OFFSET_Y] = junk(pick(32'h8000, 32'h7FFF, $urandom_range(0, 400) - 200), 16);
        cfg_val[REG_OFFSET_Z] = junk(pick(32'h8000, 32'h7FFF, $urandom_range(0, 400) - 200), 16);
        cfg_val[REG_START_HEADING] = junk($urandom_range(0, 8191), 13);
        cfg_val[REG_DEAD_ZONE]     = junk(pick(0, 32767, $urandom_range(1, 200)), 15);
        cfg_val[REG_FRICTION_GAIN] = junk(pick(0, 65535, $urandom_range(32768, 65535)), 16);
        cfg_val[REG_STOP_SPEED]    = junk(pick(0, 32'h7FFF_FFFF, $urandom_range(0, 20000)), 31);
        cfg_val[REG_SHOCK_LIMIT]   = junk(pick(0, 65535, $urandom_range(0, 3000)), 16);
    endfunction

    // motion: axes mostly past the deadzone; rest: inside it, often right on the edge
    function automatic ivi_in_t make_sample(sample_mode_t mode);
        ivi_in_t s;
        int      dz;
        int      m;
        int      t;
        logic signed [15:0] raw [3];
        dz = int'(sb.dead_zone);
        for (int k = 0; k < 3; k++)
        begin
            if (mode == MODE_MOVE && $urandom_range(0, 9) != 0)
                m = dz + 1 + int'($urandom_range(0, 1500));
            else if ($urandom_range(0, 3) == 0)
                m = dz;
            else
                m = int'($urandom_range(0, dz));
            if (m >= 32768)
                t = -32768;
            else
                t = $urandom_range(0, 1) ? -m : m;
            raw[k] = (mode == MODE_NOISE) ? 16'($urandom()) : 16'(int'(sb.off[k]) + t);
        end
        s.raw_accel_x = raw[0];
        s.raw_accel_y = raw[1];
        s.raw_accel_z = raw[2];
        if (mode == MODE_NOISE || $urandom_range(0, 15) == 0)
            s.elapsed_ms = 16'($urandom());
        else
            s.elapsed_ms = 16'($urandom_range(1, 40));
        if (mode == MODE_NOISE || $urandom_range(0, 7) == 0)
            s.heading_in = 13'($urandom());
        else
            s.heading_in = 13'($urandom_range(0, FULL_TURN - 1));
        return s;
    endfunction

    task automatic run_random(int n_items);
        int           left;
        int           burst;
        int           roll;
        sample_mode_t mode;
        left = n_items;
        while (left > 0)
        begin
            roll  = $urandom_range(0, 99);
            mode  = (roll < 45) ? MODE_MOVE : (roll < 82) ? MODE_REST : MODE_NOISE;
            burst = $urandom_range(1, 30);
            if (burst > left)
                burst = left;
            left -= burst;
            repeat (burst) send_sample(make_sample(mode));
        end
    endtask

    initial
    begin : stimulus
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        in_data   <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= REG_OFFSET_X;
        cfg_data  <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset values: deadzone edge, speed saturation both ways, heading wrap, shock edge
        send(0, 0, 0, 0, 0);
        send(32767, -32768, 0, 65535, 5759);
        send(32767, -32768, 0, 65535, 5760);
        send(0, 0, 0, 10, 8191);
        send(15, -15, 16, 1000, 1);
        send(800, 0, 0, 0, 0);
        send(0, 0, -801, 0, 0);
        send(-32768, -32768, -32768, 65535, 4000);
        drain();

        // extreme tares, largest deadzone, zero friction gain (full decay), zero limits
        cfg_val[REG_OFFSET_X]      = 32'h0000_7FFF;
        cfg_val[REG_OFFSET_Y]      = 32'hFFFF_8000;
        cfg_val[REG_OFFSET_Z]      = 32'h0000_8000;
        cfg_val[REG_START_HEADING] = 32'd8191;
        cfg_val[REG_DEAD_ZONE]     = 32'd32767;
        cfg_val[REG_FRICTION_GAIN] = 32'd0;
        cfg_val[REG_STOP_SPEED]    = 32'd0;
        cfg_val[REG_SHOCK_LIMIT]   = 32'd0;
        apply_setting();
        send(-32768, 32767, 32767, 65535, 0);
        send(0, 0, 0, 0, 5759);
        send(32767, -32768, -32768, 100, 8191);
        drain();

        // zero deadzone, largest friction gain (least decay), largest stop speed and shock limit
        cfg_val[REG_OFFSET_X]      = 32'd0;
        cfg_val[REG_OFFSET_Y]      = 32'd0;
        cfg_val[REG_OFFSET_Z]      = 32'd0;
        cfg_val[REG_START_HEADING] = 32'd0;
        cfg_val[REG_DEAD_ZONE]     = 32'd0;
        cfg_val[REG_FRICTION_GAIN] = 32'd65535;
        cfg_val[REG_STOP_SPEED]    = 32'h7FFF_FFFF;
        cfg_val[REG_SHOCK_LIMIT]   = 32'd65535;
        apply_setting();
        send(1, -1, 0, 65535, 0);
        send(0, 0, 0, 1, 0);
        send(32767, 32767, 32767, 65535, 5759);
        drain();

        // no stop speed: saturated speeds decay but never snap
        cfg_val[REG_STOP_SPEED] = 32'd0;
        apply_setting();
        send(32767, 32767, -32768, 65535, 0);
        send(32767, 32767, -32768, 65535, 0);
        send(0, 0, 0, 0, 0);
        send(0, 0, 0, 0, 0);

        for (int p = 0; p < RAND_PHASES; p++)
        begin
            drain();
            if (p == 0)
            begin
                cfg_val[REG_OFFSET_X]      = 32'(RST_OFFSET);
                cfg_val[REG_OFFSET_Y]      = 32'(RST_OFFSET);
                cfg_val[REG_OFFSET_Z]      = 32'(RST_OFFSET);
                cfg_val[REG_START_HEADING] = 32'(RST_START_HEADING);
                cfg_val[REG_DEAD_ZONE]     = 32'(RST_DEAD_ZONE);
                cfg_val[REG_FRICTION_GAIN] = 32'(RST_FRICTION_GAIN);
                cfg_val[REG_STOP_SPEED]    = 32'(RST_STOP_SPEED);
                cfg_val[REG_SHOCK_LIMIT]   = 32'(RST_SHOCK_LIMIT);
            end
            else
                rand_setting();
            apply_setting();
            if (p == RAND_PHASES - 1)
            begin
                gap_pct   = 0;
                stall_pct = 0;
            end
            else
            begin
                gap_pct   = $urandom_range(0, 2) * 20;
                stall_pct = $urandom_range(0, 2) * 20;
            end
            // sink stops taking beats while samples keep coming
            if (p == 2)
                hold_req = 1'b1;
            run_random(PHASE_ITEMS);
        end
        drain();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("run: %0d samples, %0d results checked, %0d register settings, %0d cycles",
                 n_sent, sb.n_checked, n_settings, cycle_cnt);
        $display("run: %0d shock flags, %0d axes braked to a stop, %0d saturated updates",
                 sb.n_shock, sb.n_snap, sb.n_sat);
        if (sb.n_err == 0)
            $display("imu_velocity_integrator_tb OK");
        else
            $display("imu_velocity_integrator_tb NOT OK");
        $finish;
    end

endmodule
